// File: src/fett_pkg.sv
// Shared types and constants for the fault escalation trust tracker.
package fett_pkg;

    typedef enum logic [2:0] {
        REQ_INIT     = 3'd0,
        REQ_SET      = 3'd1,
        REQ_FAULT    = 3'd2,
        REQ_QUAR     = 3'd3,
        REQ_REVOKE   = 3'd4,
        REQ_RESTORE  = 3'd5,
        REQ_TICK     = 3'd6,
        REQ_QUERY    = 3'd7
    } req_t;

    localparam logic [2:0] LV_UNKNOWN    = 3'd0;
    localparam logic [2:0] LV_TRUSTED    = 3'd1;
    localparam logic [2:0] LV_DEGRADED   = 3'd2;
    localparam logic [2:0] LV_QUARANTINE = 3'd3;
    localparam logic [2:0] LV_REVOKED    = 3'd4;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_INVAL    = 2'd1;
    localparam logic [1:0] STS_NOTFOUND = 2'd2;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SUSPEND = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;
    localparam logic [1:0] ACT_RESUME  = 2'd3;

    localparam logic [2:0] RUN_READY     = 3'd1;
    localparam logic [2:0] RUN_RUNNING   = 3'd2;
    localparam logic [2:0] RUN_SUSPENDED = 3'd3;
    localparam logic [2:0] RUN_STOPPED   = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGRADE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAR_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_US    = 2'd2;

    localparam logic [15:0] DEGRADE_THR_RST = 16'd3;
    localparam logic [15:0] QUAR_THR_RST    = 16'd10;
    localparam logic [31:0] CLEAN_US_RST    = 32'd10000000;

    localparam int PROMO_W = 9;

    typedef struct packed {
        logic [2:0]  level;
        logic [15:0] faults;
        logic [63:0] last_time;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SCAN_END,
        S_READ,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic rd_scan;
        logic scan_exec;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic ready;
    } sts_t;

endpackage

// File: src/fett_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/fett_ctrl.sv
// Controller state machine: request sequencing, slot scan counter and result handshake.
module fett_ctrl
    import fett_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  sts_t             sts,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] scan_addr
);

    ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign scan_addr = scan_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                scan_idx_next = '0;
                if (sts.is_tick && sts.ready)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_SCAN:
            begin
                cmd.rd_scan   = 1'b1;
                cmd.scan_exec = (scan_idx_reg != '0);
                if (scan_idx_reg == IDX_W'(SLOT_COUNT - 1))
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                cmd.scan_exec = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

// File: src/fett_dp.sv
// Datapath: request registers, slot memory, escalation and promotion logic, totals and results.
module fett_dp
    import fett_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [IDX_W-1:0]      scan_addr,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [2:0]            req_type,
    input  logic [7:0]            vm_id,
    input  logic [2:0]            new_level,
    input  logic [63:0]           now_us,
    input  logic                  vm_present,
    input  logic [2:0]            vm_run_state,
    output logic [1:0]            status,
    output logic [2:0]            level_now,
    output logic                  is_ok,
    output logic                  is_blocked,
    output logic [1:0]            lifecycle_action,
    output logic                  failover_request,
    output logic [PROMO_W-1:0]    promoted_count,
    output logic [15:0]           fault_count_now,
    output logic [31:0]           total_fault_count,
    output logic [31:0]           quarantine_total
);

    logic [15:0] degrade_thr_reg;
    logic [15:0] quar_thr_reg;
    logic [31:0] clean_us_reg;

    req_t        req_reg;
    logic [IDX_W-1:0] ix_reg;
    logic        id_ok_reg;
    logic [2:0]  lvl_reg;
    logic [63:0] now_reg;
    logic        present_reg;
    logic [2:0]  run_reg;

    logic        ready_reg, ready_next;
    logic [31:0] all_faults_reg, all_faults_next;
    logic [31:0] qdone_reg, qdone_next;
    logic [SLOT_COUNT-1:0] valid_bits_reg;
    logic [PROMO_W-1:0] promoted_reg;
    logic [IDX_W-1:0] rd_addr_reg;

    logic        ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;

    slot_t       cur;
    slot_t       new_slot;
    logic [15:0] faults_inc;
    logic [64:0] diff;
    logic        promote;
    logic        wr_exec;
    logic        clear_valid;
    logic [1:0]  sts_code;
    logic [1:0]  action;
    logic        failover;
    logic [2:0]  lv_out;

    logic [1:0]  status_reg;
    logic [2:0]  level_now_reg;
    logic [1:0]  action_reg;
    logic        failover_reg;
    logic [PROMO_W-1:0] promoted_out_reg;
    logic [15:0] fault_now_reg;
    logic [31:0] total_faults_out_reg;
    logic [31:0] qtotal_out_reg;

    assign sts.is_tick = (req_reg == REQ_TICK);
    assign sts.ready   = ready_reg;

    assign ram_raddr = cmd.rd_scan ? scan_addr : ix_reg;
    assign ram_we    = (cmd.exec && wr_exec) || promote;
    assign ram_wdata = promote ? SLOT_W'({LV_TRUSTED, 16'd0, cur.last_time})
                               : SLOT_W'(new_slot);

    fett_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rd_addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degrade_thr_reg <= DEGRADE_THR_RST;
            quar_thr_reg    <= QUAR_THR_RST;
            clean_us_reg    <= CLEAN_US_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_DEGRADE_THR: degrade_thr_reg <= cfg_data[15:0];
                CFG_QUAR_THR:    quar_thr_reg    <= cfg_data[15:0];
                CFG_CLEAN_US:    clean_us_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= ram_raddr;
        if (cmd.latch)
        begin
            req_reg     <= req_t'(req_type);
            ix_reg      <= IDX_W'(vm_id - 8'd1);
            id_ok_reg   <= (vm_id != 8'd0) && ({1'b0, vm_id} <= 9'(SLOT_COUNT));
            lvl_reg     <= new_level;
            now_reg     <= now_us;
            present_reg <= vm_present;
            run_reg     <= vm_run_state;
        end
        if (cmd.exec)
        begin
            status_reg           <= sts_code;
            level_now_reg        <= lv_out;
            action_reg           <= action;
            failover_reg         <= failover;
            promoted_out_reg     <= promoted_reg;
            fault_now_reg        <= id_ok_reg ? new_slot.faults : 16'd0;
            total_faults_out_reg <= all_faults_next;
            qtotal_out_reg       <= qdone_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg      <= 1'b0;
            all_faults_reg <= '0;
            qdone_reg      <= '0;
            valid_bits_reg <= '0;
            promoted_reg   <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                promoted_reg <= '0;
            end
            else if (promote)
            begin
                promoted_reg <= promoted_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                ready_reg      <= ready_next;
                all_faults_reg <= all_faults_next;
                qdone_reg      <= qdone_next;
            end
            if (cmd.exec && clear_valid)
            begin
                valid_bits_reg <= '0;
            end
            else if (ram_we)
            begin
                valid_bits_reg[rd_addr_reg] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        cur = valid_bits_reg[rd_addr_reg] ? slot_t'(ram_rdata) : '0;
        diff = {1'b0, now_reg} - {1'b0, cur.last_time};
        promote = cmd.scan_exec && (cur.level == LV_DEGRADED) && !diff[64]
                  && (diff[63:0] >= {32'd0, clean_us_reg});
        faults_inc = (cur.faults != 16'hFFFF) ? cur.faults + 16'd1 : cur.faults;
    end

    always_comb
    begin
        new_slot        = cur;
        wr_exec         = 1'b0;
        clear_valid     = 1'b0;
        sts_code        = STS_OK;
        action          = ACT_NONE;
        failover        = 1'b0;
        ready_next      = ready_reg;
        all_faults_next = all_faults_reg;
        qdone_next      = qdone_reg;
        case (req_reg)
            REQ_INIT:
            begin
                new_slot        = '0;
                clear_valid     = 1'b1;
                ready_next      = 1'b1;
                all_faults_next = '0;
                qdone_next      = '0;
            end
            REQ_SET:
            begin
                if (!id_ok_reg || !ready_reg || (lvl_reg > LV_REVOKED))
                begin
                    sts_code = STS_INVAL;
                end
                else
                begin
                    new_slot.level = lvl_reg;
                    wr_exec        = 1'b1;
                end
            end
            REQ_FAULT:
            begin
                if (!id_ok_reg || !ready_reg)
                begin
                    sts_code = STS_INVAL;
                end
                else if (cur.level != LV_REVOKED)
                begin
                    new_slot.faults    = faults_inc;
                    new_slot.last_time = now_reg;
                    wr_exec            = 1'b1;
                    if (all_faults_reg != 32'hFFFF_FFFF)
                    begin
                        all_faults_next = all_faults_reg + 32'd1;
                    end
                    if (faults_inc >= quar_thr_reg)
                    begin
                        if ((cur.level < LV_QUARANTINE) && present_reg)
                        begin
                            new_slot.level = LV_QUARANTINE;
                            failover       = 1'b1;
                            if (qdone_reg != 32'hFFFF_FFFF)
                            begin
                                qdone_next = qdone_reg + 32'd1;
                            end
                            if (run_reg inside {RUN_READY, RUN_RUNNING})
                            begin
                                action = ACT_SUSPEND;
                            end
                        end
                    end
                    else if ((faults_inc >= degrade_thr_reg) && (cur.level == LV_TRUSTED))
                    begin
                        new_slot.level = LV_DEGRADED;
                    end
                end
            end
            REQ_QUAR:
            begin
                if (!id_ok_reg)
                begin
                    sts_code = STS_INVAL;
                end
                else if (!present_reg)
                begin
                    sts_code = STS_NOTFOUND;
                end
                else if (cur.level < LV_QUARANTINE)
                begin
                    if (ready_reg)
                    begin
                        new_slot.level = LV_QUARANTINE;
                        wr_exec        = 1'b1;
                    end
                    failover = 1'b1;
                    if (qdone_reg != 32'hFFFF_FFFF)
                    begin
                        qdone_next = qdone_reg + 32'd1;
                    end
                    if (run_reg inside {RUN_READY, RUN_RUNNING})
                    begin
                        action = ACT_SUSPEND;
                    end
                end
            end
            REQ_REVOKE:
            begin
                if (!id_ok_reg)
                begin
                    sts_code = STS_INVAL;
                end
                else if (!present_reg)
                begin
                    sts_code = STS_NOTFOUND;
                end
                else
                begin
                    if (ready_reg)
                    begin
                        new_slot.level = LV_REVOKED;
                        wr_exec        = 1'b1;
                    end
                    if (run_reg != RUN_STOPPED)
                    begin
                        action = ACT_STOP;
                    end
                end
            end
            REQ_RESTORE:
            begin
                if (!id_ok_reg)
                begin
                    sts_code = STS_INVAL;
                end
                else if (!present_reg)
                begin
                    sts_code = STS_NOTFOUND;
                end
                else if (cur.level != LV_QUARANTINE)
                begin
                    sts_code = STS_INVAL;
                end
                else
                begin
                    new_slot.faults = 16'd0;
                    wr_exec         = 1'b1;
                    if (ready_reg)
                    begin
                        new_slot.level = LV_DEGRADED;
                    end
                    if (run_reg == RUN_SUSPENDED)
                    begin
                        action = ACT_RESUME;
                    end
                end
            end
            REQ_TICK:
            begin
                sts_code = STS_OK;
            end
            REQ_QUERY:
            begin
                if (!id_ok_reg)
                begin
                    sts_code = STS_INVAL;
                end
            end
            default:
            begin
                sts_code = STS_OK;
            end
        endcase
        lv_out = (id_ok_reg && ready_next) ? new_slot.level : LV_UNKNOWN;
    end

    assign status            = status_reg;
    assign level_now         = level_now_reg;
    assign is_ok             = (level_now_reg == LV_TRUSTED) || (level_now_reg == LV_DEGRADED);
    assign is_blocked        = (level_now_reg == LV_QUARANTINE) || (level_now_reg == LV_REVOKED);
    assign lifecycle_action  = action_reg;
    assign failover_request  = failover_reg;
    assign promoted_count    = promoted_out_reg;
    assign fault_count_now   = fault_now_reg;
    assign total_fault_count = total_faults_out_reg;
    assign quarantine_total  = qtotal_out_reg;

endmodule

// File: src/fault_escalation_trust_tracker.sv
// Top level of the fault escalation trust tracker: controller, datapath and ports.
//
// Requests enter on the in channel (in_valid, in_stall) and each gives exactly one
// result on the out channel (out_valid, out_stall); a transfer happens at a clock
// edge where valid is high and stall is low. Configuration registers are written
// through cfg_write_en, cfg_index and cfg_data; the user must write them only while
// no request is in flight, as the block itself does not enforce this. A request
// other than tick passes through the start and exec states; the input stalls until
// its result is in the output register, so the block takes no new request before
// the last one is through. A tick on an initialized block walks all SLOT_COUNT
// slots through the slot memory, one slot a cycle, paced by its single port pair.
// The result sits in an output register; while the receiver stalls it holds, and
// the block can accept and work on one more request, which then waits for the
// output register to free. Reset clears the slot valid bits, totals and the
// initialized flag, and loads the register reset values; an init request clears
// the slots and totals again and marks the block initialized.
module fault_escalation_trust_tracker
    import fett_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            req_type,
    input  logic [7:0]            vm_id,
    input  logic [2:0]            new_level,
    input  logic [63:0]           now_us,
    input  logic                  vm_present,
    input  logic [2:0]            vm_run_state,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [2:0]            level_now,
    output logic                  is_ok,
    output logic                  is_blocked,
    output logic [1:0]            lifecycle_action,
    output logic                  failover_request,
    output logic [PROMO_W-1:0]    promoted_count,
    output logic [15:0]           fault_count_now,
    output logic [31:0]           total_fault_count,
    output logic [31:0]           quarantine_total
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    cmd_t cmd;
    sts_t sts;
    logic [IDX_W-1:0] scan_addr;

    fett_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    fett_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .scan_addr         (scan_addr),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .req_type          (req_type),
        .vm_id             (vm_id),
        .new_level         (new_level),
        .now_us            (now_us),
        .vm_present        (vm_present),
        .vm_run_state      (vm_run_state),
        .status            (status),
        .level_now         (level_now),
        .is_ok             (is_ok),
        .is_blocked        (is_blocked),
        .lifecycle_action  (lifecycle_action),
        .failover_request  (failover_request),
        .promoted_count    (promoted_count),
        .fault_count_now   (fault_count_now),
        .total_fault_count (total_fault_count),
        .quarantine_total  (quarantine_total)
    );

endmodule
